/* rtl/mcts_pkg.sv */
package mcts_pkg;

  localparam int KindW   = 3;
  localparam int TimeW   = 64;
  localparam int TempoW  = 20;
  localparam int LaW     = 30;
  localparam int StatusW = 8;
  localparam int IdxW    = 32;
  localparam int IvW     = 40;
  localparam int CntW    = $clog2(IvW + 1);

  typedef logic [KindW-1:0]   kind_t;
  typedef logic [TimeW-1:0]   ns_t;
  typedef logic [TempoW-1:0]  tempo_t;
  typedef logic [LaW-1:0]     lookahead_t;
  typedef logic [StatusW-1:0] status_t;

  localparam logic [IvW-1:0] IntervalNum    = 40'd640000000000;
  localparam lookahead_t     LookaheadReset = 30'd200000000;

  localparam kind_t KindStart    = 3'd0;
  localparam kind_t KindContinue = 3'd1;
  localparam kind_t KindStop     = 3'd2;
  localparam kind_t KindTempo    = 3'd3;
  localparam kind_t KindPoll     = 3'd4;

  localparam status_t StTick     = 8'hF8;
  localparam status_t StStart    = 8'hFA;
  localparam status_t StContinue = 8'hFB;
  localparam status_t StStop     = 8'hFC;

endpackage

/* rtl/midi_clock_tick_scheduler.sv */
// MIDI clock scheduler, 24 ticks per quarter note, tempo in Q12.8 BPM.
// Input channel (in_valid/in_ready) carries kind, now_ns, origin_ns, tempo;
// output channel (out_valid/out_ready) carries status_byte, time_ns, last.
// cfg_we/cfg_wdata write the lookahead in ns (reset value 200000000).
// Items are handled one at a time; in_ready is high only while idle.
// Start, continue and stop give their one message once the output is free, after the
// transfer; set tempo and ignored kinds return to idle 1 cycle after it.
// A poll runs a bit-serial divider (640e9 / tempo), an optional second
// division for a tempo reanchor, up to two bit-serial 32-bit multiplies
// and a compare state; ticks then follow one per cycle while the
// receiver takes them, at most min(MAX_TICKS, 32) per poll, the last
// marked by last = 1.
// A stalled receiver holds the output register; the block waits until the
// result is taken and loses nothing. Reset clears all scheduling state,
// drops any result in flight and restores the lookahead.
module midi_clock_tick_scheduler #(
  parameter int MAX_TICKS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  mcts_pkg::lookahead_t  cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mcts_pkg::kind_t       kind,
  input  mcts_pkg::ns_t         now_ns,
  input  mcts_pkg::ns_t         origin_ns,
  input  mcts_pkg::tempo_t      tempo,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mcts_pkg::status_t     status_byte,
  output mcts_pkg::ns_t         time_ns,
  output logic                  last
);
  import mcts_pkg::*;

  localparam int Cap = (MAX_TICKS < 32) ? MAX_TICKS : 32;
  localparam int NW  = $clog2(Cap + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_DIV_CUR = 3'd2;
  localparam logic [2:0] S_DIV_OLD = 3'd3;
  localparam logic [2:0] S_MUL     = 3'd4;
  localparam logic [2:0] S_CHECK   = 3'd5;
  localparam logic [2:0] S_TICK    = 3'd6;

  localparam logic [1:0] JOB_CONT  = 2'd0;
  localparam logic [1:0] JOB_TEMPO = 2'd1;
  localparam logic [1:0] JOB_TICK  = 2'd2;

  logic [2:0]      state;
  logic [1:0]      job;
  logic [CntW-1:0] cnt;
  logic [NW-1:0]   n;

  lookahead_t      lookahead;
  logic            active;
  tempo_t          cur_tempo;
  tempo_t          anchored_tempo;
  ns_t             origin_time;
  logic [IdxW-1:0] tick_index;
  logic            continue_pending;
  logic            tempo_pending;

  kind_t           kind_r;
  ns_t             now_r;
  ns_t             origin_r;
  tempo_t          tempo_r;

  ns_t             horizon;
  logic [IvW-1:0]  iv;
  logic [IvW-1:0]  dq;
  tempo_t          rem;
  tempo_t          div_d;
  ns_t             mcand;
  logic [IdxW-1:0] mplier;
  ns_t             acc;
  ns_t             t;

  logic [TempoW:0] rem_sh;
  logic [TempoW:0] rem_sub;
  logic            div_ge;
  tempo_t          rem_next;
  logic [IvW-1:0]  q_next;
  logic            div_done;
  ns_t             mul_add;
  ns_t             t_next;
  logic            tick_last;
  logic            slot_free;

  always_comb begin
    rem_sh    = {rem, dq[IvW-1]};
    rem_sub   = rem_sh - {1'b0, div_d};
    div_ge    = rem_sh >= {1'b0, div_d};
    rem_next  = div_ge ? rem_sub[TempoW-1:0] : rem_sh[TempoW-1:0];
    q_next    = {dq[IvW-2:0], div_ge};
    div_done  = cnt == CntW'(IvW - 1);
    mul_add   = acc + (mplier[0] ? mcand : '0);
    t_next    = (tick_index == '1) ? origin_time : t + {{(TimeW-IvW){1'b0}}, iv};
    tick_last = (n == NW'(Cap - 1)) || (t_next > horizon);
    slot_free = !out_valid || out_ready;
  end

  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      lookahead        <= LookaheadReset;
      active           <= 1'b0;
      cur_tempo        <= '0;
      anchored_tempo   <= '0;
      origin_time      <= '0;
      tick_index       <= '0;
      continue_pending <= 1'b0;
      tempo_pending    <= 1'b0;
      job              <= JOB_TICK;
      cnt              <= '0;
      n                <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        lookahead <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind_r   <= kind;
            now_r    <= now_ns;
            origin_r <= origin_ns;
            tempo_r  <= tempo;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (kind_r)
            KindStart: begin
              if (slot_free) begin
                cur_tempo        <= tempo_r;
                anchored_tempo   <= tempo_r;
                origin_time      <= origin_r;
                tick_index       <= '0;
                continue_pending <= 1'b0;
                tempo_pending    <= 1'b0;
                active           <= 1'b1;
                out_valid        <= 1'b1;
                status_byte      <= StStart;
                time_ns          <= origin_r;
                last             <= 1'b1;
                state            <= S_IDLE;
              end
            end
            KindContinue: begin
              if (slot_free) begin
                cur_tempo        <= tempo_r;
                continue_pending <= 1'b1;
                active           <= 1'b1;
                out_valid        <= 1'b1;
                status_byte      <= StContinue;
                time_ns          <= now_r;
                last             <= 1'b1;
                state            <= S_IDLE;
              end
            end
            KindStop: begin
              if (slot_free) begin
                active      <= 1'b0;
                out_valid   <= 1'b1;
                status_byte <= StStop;
                time_ns     <= now_r;
                last        <= 1'b1;
                state       <= S_IDLE;
              end
            end
            KindTempo: begin
              cur_tempo     <= tempo_r;
              tempo_pending <= 1'b1;
              state         <= S_IDLE;
            end
            KindPoll: begin
              if (!active || cur_tempo == '0) begin
                state <= S_IDLE;
              end else begin
                horizon <= now_r + {{(TimeW-LaW){1'b0}}, lookahead};
                dq      <= IntervalNum;
                rem     <= '0;
                div_d   <= cur_tempo;
                cnt     <= '0;
                state   <= S_DIV_CUR;
              end
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_DIV_CUR: begin
          dq  <= q_next;
          rem <= rem_next;
          cnt <= cnt + CntW'(1);
          if (div_done) begin
            iv             <= q_next;
            anchored_tempo <= cur_tempo;
            acc            <= '0;
            mplier         <= tick_index;
            cnt            <= '0;
            priority if (continue_pending) begin
              continue_pending <= 1'b0;
              mcand            <= {{(TimeW-IvW){1'b0}}, q_next};
              job              <= JOB_CONT;
              state            <= S_MUL;
            end else if (tempo_pending && anchored_tempo == '0) begin
              tempo_pending <= 1'b0;
              mcand         <= '0 - {{(TimeW-IvW){1'b0}}, q_next};
              job           <= JOB_TEMPO;
              state         <= S_MUL;
            end else if (tempo_pending) begin
              dq    <= IntervalNum;
              rem   <= '0;
              div_d <= anchored_tempo;
              state <= S_DIV_OLD;
            end else begin
              mcand <= {{(TimeW-IvW){1'b0}}, q_next};
              job   <= JOB_TICK;
              state <= S_MUL;
            end
          end
        end
        S_DIV_OLD: begin
          dq  <= q_next;
          rem <= rem_next;
          cnt <= cnt + CntW'(1);
          if (div_done) begin
            tempo_pending <= 1'b0;
            mcand <= {{(TimeW-IvW){1'b0}}, q_next} - {{(TimeW-IvW){1'b0}}, iv};
            job   <= JOB_TEMPO;
            cnt   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (cnt == CntW'(IdxW)) begin
            acc    <= '0;
            mplier <= tick_index;
            mcand  <= {{(TimeW-IvW){1'b0}}, iv};
            cnt    <= '0;
            job    <= JOB_TICK;
            unique case (job)
              JOB_CONT:  origin_time <= now_r - acc;
              JOB_TEMPO: origin_time <= origin_time + acc;
              default: begin
                t     <= origin_time + acc;
                state <= S_CHECK;
              end
            endcase
          end else begin
            acc    <= mul_add;
            mcand  <= {mcand[TimeW-2:0], 1'b0};
            mplier <= {1'b0, mplier[IdxW-1:1]};
            cnt    <= cnt + CntW'(1);
          end
        end
        S_CHECK: begin
          n     <= '0;
          state <= (t > horizon) ? S_IDLE : S_TICK;
        end
        S_TICK: begin
          if (slot_free) begin
            out_valid   <= 1'b1;
            status_byte <= StTick;
            time_ns     <= t;
            last        <= tick_last;
            tick_index  <= tick_index + IdxW'(1);
            t           <= t_next;
            n           <= n + NW'(1);
            if (tick_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/mcts_checker.sv */
module mcts_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input mcts_pkg::status_t status_byte,
  input mcts_pkg::ns_t     time_ns,
  input logic              last
);
  import mcts_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present right after reset");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status_byte == StTick || status_byte == StStart ||
                   status_byte == StContinue || status_byte == StStop))
    else $error("illegal status byte");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status_byte != StTick |-> last)
    else $error("transport message without last");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status_byte) &&
                                $stable(time_ns) && $stable(last))
    else $error("stalled result changed");

endmodule

bind midi_clock_tick_scheduler mcts_checker u_mcts_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status_byte (status_byte),
  .time_ns     (time_ns),
  .last        (last)
);

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mcts_pkg::*;

  localparam int MaxTicks = 32;
  localparam int TickCap  = (MaxTicks < 32) ? MaxTicks : 32;

  typedef struct packed {
    status_t st;
    ns_t     at;
    logic    lst;
  } msg_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_we    = 1'b0;
  lookahead_t cfg_wdata = '0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  kind_t      kind      = KindPoll;
  ns_t        now_ns    = '0;
  ns_t        origin_ns = '0;
  tempo_t     tempo     = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  status_t    status_byte;
  ns_t        time_ns;
  logic       last;

  msg_t due_msgs[$];
  int   errors = 0;
  int   n_in   = 0;
  int   n_out  = 0;
  int   n_cfg  = 0;
  bit   no_idle = 1'b0;

  // shadow of the scheduler state
  bit          run_on       = 1'b0;
  tempo_t      tempo_now    = '0;
  tempo_t      tempo_anchor = '0;
  ns_t         tick_origin  = '0;
  logic [31:0] tick_num     = '0;
  bit          cont_flag    = 1'b0;
  bit          tempo_flag   = 1'b0;
  ns_t         look_ns      = ns_t'(LookaheadReset);

  midi_clock_tick_scheduler #(
    .MAX_TICKS(MaxTicks)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .now_ns     (now_ns),
    .origin_ns  (origin_ns),
    .tempo      (tempo),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status_byte(status_byte),
    .time_ns    (time_ns),
    .last       (last)
  );

  always #4 clk = ~clk;

  function automatic ns_t tick_period(tempo_t t);
    if (t == '0) return '0;
    return ns_t'(IntervalNum) / ns_t'(t);
  endfunction

  function automatic tempo_t q_bpm(int b);
    return tempo_t'(b * 256);
  endfunction

  function automatic ns_t rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic tempo_t pick_tempo();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return tempo_t'($urandom_range(30 * 256, 300 * 256));
    if (r < 93) return tempo_t'($urandom_range(1, 20'hFFFFF));
    if (r < 97) return 20'hFFFFF;
    return '0;
  endfunction

  function automatic lookahead_t pick_lookahead();
    unique case ($urandom_range(0, 5))
      0: return '0;
      1: return lookahead_t'(1_000_000_000);
      2: return '1;
      3: return LookaheadReset;
      4: return lookahead_t'($urandom);
      default: return lookahead_t'($urandom_range(0, 1_000_000_000));
    endcase
  endfunction

  function automatic void queue_msg(status_t s, ns_t a, logic l);
    msg_t m;
    m = '{st: s, at: a, lst: l};
    due_msgs.insert(due_msgs.size(), m);
  endfunction

  // apply one transfer to the shadow state and queue the messages it schedules
  task automatic schedule_item(kind_t k, ns_t now, ns_t org, tempo_t tp);
    ns_t period;
    ns_t idx;
    ns_t next_t;
    ns_t horizon;
    ns_t t;
    int  n;
    unique case (k)
      KindStart: begin
        tempo_now    = tp;
        tempo_anchor = tp;
        tick_origin  = org;
        tick_num     = '0;
        cont_flag    = 1'b0;
        tempo_flag   = 1'b0;
        run_on       = 1'b1;
        queue_msg(StStart, org, 1'b1);
        return;
      end
      KindContinue: begin
        tempo_now = tp;
        cont_flag = 1'b1;
        run_on    = 1'b1;
        queue_msg(StContinue, now, 1'b1);
        return;
      end
      KindStop: begin
        run_on = 1'b0;
        queue_msg(StStop, now, 1'b1);
        return;
      end
      KindTempo: begin
        tempo_now  = tp;
        tempo_flag = 1'b1;
        return;
      end
      KindPoll: ;
      default: return;
    endcase
    if (!run_on || tempo_now == '0) return;
    period = tick_period(tempo_now);
    idx    = ns_t'(tick_num);
    if (cont_flag) begin
      cont_flag   = 1'b0;
      tick_origin = now - idx * period;
    end else if (tempo_flag) begin
      tempo_flag  = 1'b0;
      next_t      = tick_origin + idx * tick_period(tempo_anchor);
      tick_origin = next_t - idx * period;
    end
    tempo_anchor = tempo_now;
    horizon = now + look_ns;
    n = 0;
    while (n < TickCap) begin
      t = tick_origin + ns_t'(tick_num) * period;
      if (t > horizon) break;
      queue_msg(StTick, t, 1'b0);
      n++;
      tick_num = tick_num + 1;
    end
    if (n > 0) due_msgs[due_msgs.size() - 1].lst = 1'b1;
  endtask

  // valid stays high after the transfer until the next item or settle() drops it
  task automatic send_item(kind_t k, ns_t now, ns_t org, tempo_t tp);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    now_ns    <= now;
    origin_ns <= org;
    tempo     <= tp;
    do @(posedge clk); while (!in_ready);
    schedule_item(k, now, org, tp);
    if (k <= KindPoll) n_in++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_msgs.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_lookahead(lookahead_t v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    look_ns = ns_t'(v);
    n_cfg++;
  endtask

  initial begin : sink_pace
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = gap_len();
      end
    end
  end

  always @(posedge clk) begin : check_msgs
    msg_t want;
    if (!rst && out_valid && out_ready) begin
      n_out++;
      if (due_msgs.size() == 0) begin
        errors++;
        $error("unexpected transfer: status_byte %0h time_ns %0d last %0b",
               status_byte, time_ns, last);
      end else begin
        want = due_msgs[0];
        due_msgs.delete(0);
        if (status_byte !== want.st) begin
          errors++;
          $error("status_byte: expected %0h, actual %0h", want.st, status_byte);
        end
        if (time_ns !== want.at) begin
          errors++;
          $error("time_ns: expected %0d, actual %0d", want.at, time_ns);
        end
        if (last !== want.lst) begin
          errors++;
          $error("last: expected %0b, actual %0b", want.lst, last);
        end
      end
    end
  end

  task automatic test_transport_basics();
    ns_t t0;
    t0 = 64'd1_000_000_000;
    no_idle = 1'b1;
    send_item(KindStart, '0, t0, q_bpm(120));
    send_item(KindPoll, t0, '0, '0);
    send_item(KindPoll, t0 + 64'd150_000_000, '0, '0);
    send_item(KindTempo, '0, '0, q_bpm(140) + 20'd128);
    send_item(KindPoll, t0 + 64'd300_000_000, '0, '0);
    send_item(KindContinue, t0 + 64'd400_000_000, '0, q_bpm(90));
    send_item(KindPoll, t0 + 64'd400_000_000, '0, '0);
    send_item(KindStop, t0 + 64'd500_000_000, '0, '0);
    send_item(KindPoll, t0 + 64'd520_000_000, '0, '0);
    send_item(KindTempo, '0, '0, q_bpm(100));
    send_item(3'd5, rand64(), rand64(), tempo_t'($urandom));
    send_item(3'd6, rand64(), rand64(), tempo_t'($urandom));
    send_item(3'd7, rand64(), rand64(), tempo_t'($urandom));
    no_idle = 1'b0;
  endtask

  task automatic test_edge_values();
    send_item(KindStart, '0, '0, '0);
    send_item(KindPoll, '0, '0, '0);
    send_item(KindTempo, '0, '0, 20'hFFFFF);
    send_item(KindPoll, 64'd1000, '0, '0);
    send_item(KindPoll, 64'd1000, '0, '0);
    send_item(KindContinue, 64'd500, '0, '0);
    send_item(KindPoll, 64'd500, '0, '0);
    send_item(KindTempo, '0, '0, 20'd1);
    send_item(KindPoll, 64'd500, '0, '0);
    send_item(KindPoll, 64'd500, '0, '0);
    send_item(KindStart, '0, '1, 20'hFFFFF);
    send_item(KindPoll, '1, '0, '0);
    send_item(KindContinue, '1, '0, 20'hFFFFF);
    send_item(KindPoll, '1, '0, '0);
    send_item(KindStop, '1, '0, '0);
  endtask

  task automatic test_lookahead_range();
    ns_t t0;
    t0 = 64'd1_000_000;
    write_lookahead('0);
    send_item(KindStart, '0, t0, q_bpm(120));
    send_item(KindPoll, t0, '0, '0);
    send_item(KindPoll, t0 + 64'd20_833_332, '0, '0);
    send_item(KindPoll, t0 + 64'd20_833_333, '0, '0);
    write_lookahead(lookahead_t'(1_000_000_000));
    send_item(KindPoll, t0 + 64'd20_833_333, '0, '0);
    write_lookahead('1);
    send_item(KindPoll, t0 + 64'd20_833_333, '0, '0);
    write_lookahead(LookaheadReset);
  endtask

  task automatic test_random_sessions(int quota);
    int  done;
    int  r;
    ns_t clock_ns;
    kind_t k;
    done     = 0;
    clock_ns = 64'd5_000_000;
    while (done < quota) begin
      if ($urandom_range(0, 4) == 0) write_lookahead(pick_lookahead());
      no_idle = ($urandom_range(0, 5) == 0);
      clock_ns += $urandom_range(0, 100_000_000);
      send_item(KindStart, '0, clock_ns + $urandom_range(0, 40_000_000), pick_tempo());
      done++;
      repeat ($urandom_range(4, 20)) begin
        r = $urandom_range(0, 99);
        if (r < 90) clock_ns += $urandom_range(1_000_000, 30_000_000);
        else if (r < 97) clock_ns += $urandom_range(30_000_000, 400_000_000);
        else clock_ns += $urandom_range(400_000_000, 2_000_000_000);
        r = $urandom_range(0, 99);
        if (r < 60) begin
          send_item(KindPoll, clock_ns, rand64(), tempo_t'($urandom));
        end else if (r < 70) begin
          send_item(KindTempo, rand64(), rand64(), pick_tempo());
        end else if (r < 78) begin
          send_item(KindContinue, clock_ns, rand64(), pick_tempo());
        end else if (r < 84) begin
          send_item(KindStop, clock_ns, rand64(), tempo_t'($urandom));
        end else if (r < 92) begin
          k = kind_t'($urandom_range(0, 7));
          send_item(k, rand64(), rand64(), tempo_t'($urandom));
          if (k > KindPoll) done--;
        end else begin
          send_item(KindPoll, rand64(), rand64(), tempo_t'($urandom));
        end
        done++;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_transport_basics();
    test_edge_values();
    test_lookahead_range();
    test_random_sessions(435);
    settle();
    $display("covered %0d input transfers and %0d checked output transfers",
             n_in, n_out);
    $display("across start/continue/stop/tempo/poll and %0d lookahead writes", n_cfg);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #(40_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule
